FILE: rtl/core/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and fixed-point constants of the polar circle rasterizer.
// ----------------------------------------------------------------------------
package pcr_pkg;

  localparam int COORD_BITS    = 16;
  localparam int COLOR_BITS    = 24;
  localparam int RADIUS_BITS   = 25;  // unsigned Q17.8
  localparam int STEP_BITS     = 25;  // Q1.24 radians
  localparam int ANGLE_BITS    = 27;  // Q3.24 radians
  localparam int Z_BITS        = 29;  // signed residue angle
  localparam int UNIT_BITS     = 32;  // signed Q2.28 unit vector
  localparam int CORDIC_STAGES = 24;
  localparam int STAGE_IDX_W   = 5;
  localparam int ROUND_SHIFT   = 36;  // 8 radius + 28 unit fraction bits

  localparam logic [ANGLE_BITS-1:0] HALF_PI = 27'd26353589;
  localparam logic [ANGLE_BITS-1:0] TWO_PI  = 27'd105414357;
  localparam logic [UNIT_BITS-1:0]  GAIN    = 32'd163008219;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic                         load;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic [COLOR_BITS-1:0]        color;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
    logic                  error;
  } res_t;

  // arctan(2^-i) in Q.24, rounded to nearest
  function automatic logic [Z_BITS-1:0] atan_q24(input logic [STAGE_IDX_W-1:0] i);
    logic [Z_BITS-1:0] r;
    case (i)
      5'd0:    r = 29'd13176795;
      5'd1:    r = 29'd7778716;
      5'd2:    r = 29'd4110060;
      5'd3:    r = 29'd2086331;
      5'd4:    r = 29'd1047214;
      5'd5:    r = 29'd524117;
      5'd6:    r = 29'd262123;
      5'd7:    r = 29'd131069;
      5'd8:    r = 29'd65536;
      5'd9:    r = 29'd32768;
      5'd10:   r = 29'd16384;
      5'd11:   r = 29'd8192;
      5'd12:   r = 29'd4096;
      5'd13:   r = 29'd2048;
      5'd14:   r = 29'd1024;
      5'd15:   r = 29'd512;
      5'd16:   r = 29'd256;
      5'd17:   r = 29'd128;
      5'd18:   r = 29'd64;
      5'd19:   r = 29'd32;
      5'd20:   r = 29'd16;
      5'd21:   r = 29'd8;
      5'd22:   r = 29'd4;
      5'd23:   r = 29'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/pcr_front.sv
// ----------------------------------------------------------------------------
// pcr_front
// Accepts input transfers, classifies them (load or step), forms the edge
// offsets and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pcr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [87:0]     in_tdata,   // mid_x, mid_y, edge_x, edge_y, color
  input  logic            in_tuser,   // cmd
  output pcr_pkg::q_head_t q_head,
  input  logic            q_pop
);

  pcr_pkg::item_t  mem [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push, pop;
  pcr_pkg::item_t  new_item;
  logic signed [pcr_pkg::COORD_BITS-1:0] cx, cy, ex, ey;

  assign cx = in_tdata[15:0];
  assign cy = in_tdata[31:16];
  assign ex = in_tdata[47:32];
  assign ey = in_tdata[63:48];

  always_comb begin
    new_item.load  = (in_tuser == pcr_pkg::CMD_LOAD);
    new_item.cx    = cx;
    new_item.cy    = cy;
    new_item.dx    = 17'(ex) - 17'(cx);
    new_item.dy    = 17'(ey) - 17'(cy);
    new_item.color = in_tdata[87:64];
  end

  assign in_tready    = (cnt_r != 2'd2);
  assign push         = in_tvalid && in_tready;
  assign pop          = q_pop && (cnt_r != 2'd0);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/pcr_back.sv
// ----------------------------------------------------------------------------
// pcr_back
// Sequencer that carries out queued items: radius by digit-recurrence square
// root, angle step by restoring division, pixel by iterative CORDIC, then
// scale, round and saturate.
// ----------------------------------------------------------------------------
module pcr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pcr_pkg::q_head_t q_head,
  output logic             q_pop,
  output logic             res_valid,
  output pcr_pkg::res_t    res,
  input  logic             res_ready
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQR  = 10'b0000000010,
    S_SUM  = 10'b0000000100,
    S_ROOT = 10'b0000001000,
    S_DIV  = 10'b0000010000,
    S_ROT  = 10'b0000100000,
    S_MUL  = 10'b0001000000,
    S_ABS  = 10'b0010000000,
    S_RND  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // circle state
  logic                                   active_r;
  logic signed [pcr_pkg::COORD_BITS-1:0]  cx_r, cy_r;
  logic [pcr_pkg::COLOR_BITS-1:0]         color_r;
  logic [pcr_pkg::RADIUS_BITS-1:0]        radius_r;
  logic [pcr_pkg::STEP_BITS-1:0]          step_r;
  logic [pcr_pkg::ANGLE_BITS-1:0]         acc_r;

  // working registers
  pcr_pkg::item_t                         item_r;
  logic [33:0]                            sqa_r, sqb_r, sqsh_r;
  logic [26:0]                            rem_r;
  logic [pcr_pkg::RADIUS_BITS-1:0]        root_r;
  logic [pcr_pkg::STEP_BITS-1:0]          quo_r;
  logic [5:0]                             cnt_r;
  logic signed [pcr_pkg::UNIT_BITS-1:0]   x_r, y_r;
  logic signed [pcr_pkg::Z_BITS-1:0]      z_r;
  logic [1:0]                             quad_r;
  logic signed [57:0]                     prx_r, pry_r;
  logic [59:0]                            magx_r, magy_r;
  logic                                   negx_r, negy_r;
  logic [pcr_pkg::COORD_BITS-1:0]         pix_x_r, pix_y_r;
  logic [pcr_pkg::COLOR_BITS-1:0]         pix_color_r;
  logic                                   last_r, err_r;

  // combinational helpers
  logic signed [33:0]                     pa, pb;
  logic [33:0]                            sq;
  logic [28:0]                            rem_sh, trial;
  logic                                   root_ge;
  logic [pcr_pkg::RADIUS_BITS-1:0]        root_new;
  logic [25:0]                            dsh;
  logic                                   div_ge;
  logic [pcr_pkg::STEP_BITS-1:0]          quo_new;
  logic [2:0]                             q;
  logic [pcr_pkg::Z_BITS-1:0]             qhp;
  logic [pcr_pkg::ANGLE_BITS-1:0]         acc_new;
  logic [pcr_pkg::STAGE_IDX_W-1:0]        idx;
  logic signed [pcr_pkg::UNIT_BITS-1:0]   xs, ys, c, s;
  logic signed [pcr_pkg::Z_BITS-1:0]      at;
  logic signed [59:0]                     vx, vy;

  function automatic logic [pcr_pkg::COORD_BITS-1:0] round_sat(input logic [59:0] mag,
                                                               input logic neg);
    logic [59:0] sum;
    logic [23:0] rm;
    logic [pcr_pkg::COORD_BITS-1:0] r;
    sum = mag + (60'd1 << (pcr_pkg::ROUND_SHIFT - 1));
    rm  = sum[59:36];
    if (neg) begin
      if (rm > 24'd32768) r = 16'h8000;
      else                r = 16'(~rm[15:0] + 16'd1);
    end else begin
      if (rm > 24'd32767) r = 16'h7fff;
      else                r = rm[15:0];
    end
    return r;
  endfunction

  always_comb begin
    pa = item_r.dx * item_r.dx;
    pb = item_r.dy * item_r.dy;
    sq = sqa_r + sqb_r;

    rem_sh   = {rem_r, sqsh_r[33:32]};
    trial    = {2'b00, root_r, 2'b01};
    root_ge  = (rem_sh >= trial);
    root_new = {root_r[23:0], root_ge};

    dsh     = {rem_r[24:0], (cnt_r == 6'd0)};
    div_ge  = (dsh >= {1'b0, radius_r});
    quo_new = {quo_r[23:0], div_ge};

    q = 3'(acc_r >= pcr_pkg::HALF_PI) + 3'(acc_r >= 27'(2 * pcr_pkg::HALF_PI)) +
        3'(acc_r >= 27'(3 * pcr_pkg::HALF_PI)) + 3'(acc_r >= 27'(4 * pcr_pkg::HALF_PI));
    case (q)
      3'd0:    qhp = '0;
      3'd1:    qhp = 29'(pcr_pkg::HALF_PI);
      3'd2:    qhp = 29'(2 * pcr_pkg::HALF_PI);
      3'd3:    qhp = 29'(3 * pcr_pkg::HALF_PI);
      default: qhp = 29'(4 * pcr_pkg::HALF_PI);
    endcase
    acc_new = 27'(acc_r + 27'(step_r));

    idx = cnt_r[4:0];
    xs  = x_r >>> idx;
    ys  = y_r >>> idx;
    at  = pcr_pkg::atan_q24(idx);

    case (quad_r)
      2'd0:    begin c = x_r;  s = y_r;  end
      2'd1:    begin c = -y_r; s = x_r;  end
      2'd2:    begin c = -x_r; s = -y_r; end
      default: begin c = y_r;  s = -x_r; end
    endcase

    vx = $signed({{8{cx_r[15]}}, cx_r, 36'b0}) + 60'(prx_r);
    vy = $signed({{8{cy_r[15]}}, cy_r, 36'b0}) + 60'(pry_r);
  end

  assign q_pop     = (state_r == S_IDLE) && q_head.valid;
  assign res_valid = (state_r == S_OUT);
  assign res.pixel_x     = pix_x_r;
  assign res.pixel_y     = pix_y_r;
  assign res.pixel_color = pix_color_r;
  assign res.last        = last_r;
  assign res.error       = err_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          if (q_head.item.load) state_nxt = S_SQR;
          else if (active_r)    state_nxt = S_ROT;
        end
      end
      S_SQR:  state_nxt = S_SUM;
      S_SUM:  state_nxt = (sq == '0) ? S_OUT : S_ROOT;
      S_ROOT: if (cnt_r == 6'd24) state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd32) state_nxt = S_IDLE;
      S_ROT:  if (cnt_r == 6'(pcr_pkg::CORDIC_STAGES - 1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ABS;
      S_ABS:  state_nxt = S_RND;
      S_RND:  state_nxt = S_OUT;
      S_OUT:  if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      radius_r <= '0;
      step_r   <= '0;
      acc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_head.valid) begin
            item_r <= q_head.item;
            cnt_r  <= '0;
            if (q_head.item.load) begin
              active_r <= 1'b0;
            end else if (active_r) begin
              x_r    <= pcr_pkg::GAIN;
              y_r    <= '0;
              z_r    <= $signed({2'b00, acc_r} - qhp);
              quad_r <= q[1:0];
              acc_r  <= acc_new;
              last_r <= (acc_new >= pcr_pkg::TWO_PI);
              err_r  <= 1'b0;
              if (acc_new >= pcr_pkg::TWO_PI) active_r <= 1'b0;
            end
          end
        end
        S_SQR: begin
          sqa_r <= pa;
          sqb_r <= pb;
        end
        S_SUM: begin
          if (sq == '0) begin
            pix_x_r     <= '0;
            pix_y_r     <= '0;
            pix_color_r <= '0;
            last_r      <= 1'b0;
            err_r       <= 1'b1;
          end else begin
            cx_r    <= item_r.cx;
            cy_r    <= item_r.cy;
            color_r <= item_r.color;
            sqsh_r  <= sq;
            rem_r   <= '0;
            root_r  <= '0;
          end
        end
        S_ROOT: begin
          rem_r  <= root_ge ? 27'(rem_sh - trial) : rem_sh[26:0];
          root_r <= root_new;
          sqsh_r <= {sqsh_r[31:0], 2'b00};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd24) begin
            radius_r <= root_new;
            rem_r    <= '0;
            quo_r    <= '0;
            cnt_r    <= '0;
          end
        end
        S_DIV: begin
          rem_r <= div_ge ? 27'(dsh - {1'b0, radius_r}) : 27'(dsh);
          quo_r <= quo_new;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) begin
            step_r   <= (quo_new == '0) ? 25'd1 : quo_new;
            acc_r    <= '0;
            active_r <= 1'b1;
          end
        end
        S_ROT: begin
          if (!z_r[pcr_pkg::Z_BITS-1]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          cnt_r <= cnt_r + 6'd1;
        end
        S_MUL: begin
          prx_r <= $signed({1'b0, radius_r}) * c;
          pry_r <= $signed({1'b0, radius_r}) * s;
        end
        S_ABS: begin
          negx_r <= vx[59];
          negy_r <= vy[59];
          magx_r <= vx[59] ? 60'(-vx) : 60'(vx);
          magy_r <= vy[59] ? 60'(-vy) : 60'(vy);
        end
        S_RND: begin
          pix_x_r     <= round_sat(magx_r, negx_r);
          pix_y_r     <= round_sat(magy_r, negy_r);
          pix_color_r <= color_r;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/polar_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// polar_circle_rasterizer
// Circle outline rasterizer: radius by square root, CORDIC per pixel.
// ----------------------------------------------------------------------------
// Input stream: tuser = 0 loads a circle (center, edge point, color);
// tuser = 1 requests the next pixel. A load gives no output unless the edge
// point equals the center, which gives one transfer with tuser (error) set
// and stops drawing. A pixel request while no circle is active is dropped.
// Output stream: one transfer per pixel, tlast on the pixel after which the
// angle reaches two pi.
// Timing: a load computes 25 root digits plus 33 quotient bits, one per
// cycle; a pixel runs the 24 CORDIC iterations of the single rotation unit,
// then scale and rounding.
// Items are processed one at a time; a two-entry input queue keeps accepting
// while the back end works, and the output register lets the next item start
// while a result waits for out_tready. A stalled receiver eventually stops
// the back end and then fills the queue, dropping in_tready.
// Reset (rst_n low, synchronous) empties queue and output and leaves no
// circle active.
// ----------------------------------------------------------------------------
module polar_circle_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // mid_x, mid_y, edge_x, edge_y, color
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // pixel_x, pixel_y, pixel_color
  output logic        out_tlast,  // last
  output logic        out_tuser   // error
);

  pcr_pkg::q_head_t q_head;
  logic             q_pop;
  logic             res_valid, res_ready;
  pcr_pkg::res_t    res, out_r;
  logic             out_valid_r;

  pcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  pcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.pixel_color, out_r.pixel_y, out_r.pixel_x};
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.error;

endmodule

FILE: sim/polar_circle_rasterizer_test.sv
// ----------------------------------------------------------------------------
// polar_circle_rasterizer_test
// Streams circle loads and pixel requests into the rasterizer, predicts every
// pixel and error transfer in fixed point, and compares them in order.
// ----------------------------------------------------------------------------
module polar_circle_rasterizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     N_RANDOM    = 1630;
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  polar_circle_rasterizer uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [23:0] color;
    logic        last;
    logic        error;
  } pixel_t;

  typedef struct {
    logic        cmd;
    logic [15:0] cx, cy, ex, ey;
    logic [23:0] color;
    logic        fixed;   // expected result typed in below
    pixel_t      want;
  } row_t;

  // model state
  logic        drawing;
  longint      ctr_x, ctr_y;
  longint      radius_q8, step_q24, angle_q24;
  logic [23:0] ink;

  pixel_t pending_pixels[$];
  int     fail_count = 0;
  int     send_idle = 0, recv_stall = 0;
  bit     hold_off = 1'b0;
  longint cycle_count = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint two_pi_shifted(int shift);
    logic [63:0] v;
    v = (TWO_PI_Q60 + (64'd1 << (shift - 1))) >> shift;
    return longint'(v);
  endfunction

  function automatic longint arctan_q24(int i);
    longint sum, term;
    int e;
    sum = 0;
    if (i == 0) return two_pi_shifted(39);
    for (int k = 0; ; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e < 0) break;
      term = longint'((64'd1 << e) / (2 * k + 1));
      sum += (k & 1) ? -term : term;
    end
    return longint'((64'(sum) + (64'd1 << 35)) >> 36);
  endfunction

  function automatic longint isqrt_q8(longint sq);
    longint root, rem, trial, bits;
    root = 0;
    rem = 0;
    for (int p = 33; p >= 0; p--) begin
      bits = (p >= 8) ? ((sq >> (2 * (p - 8))) & 3) : 0;
      rem = (rem << 2) | bits;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [15:0] round_sat(longint center, longint unit);
    longint v, r;
    v = center * (longint'(1) << 36) + radius_q8 * unit;
    if (v >= 0) r = (v + (longint'(1) << 35)) >>> 36;
    else r = -((-v + (longint'(1) << 35)) >>> 36);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // returns 1 when the item yields a transfer
  function automatic bit rasterize(input logic cmd, input logic [15:0] cx, cy, ex, ey,
                                   input logic [23:0] color, output pixel_t px);
    longint dx, dy, sq, half_pi, q, x, y, z, t, c, s, at;
    px = '{default: '0};
    if (cmd == pcr_pkg::CMD_LOAD) begin
      dx = longint'($signed(ex)) - longint'($signed(cx));
      dy = longint'($signed(ey)) - longint'($signed(cy));
      sq = dx * dx + dy * dy;
      drawing = 1'b0;
      if (sq == 0) begin
        px.error = 1'b1;
        return 1'b1;
      end
      ctr_x = longint'($signed(cx));
      ctr_y = longint'($signed(cy));
      ink = color;
      radius_q8 = isqrt_q8(sq);
      step_q24 = (longint'(1) << 32) / radius_q8;
      if (step_q24 == 0) step_q24 = 1;
      angle_q24 = 0;
      drawing = 1'b1;
      return 1'b0;
    end
    if (!drawing) return 1'b0;
    half_pi = two_pi_shifted(38);
    q = angle_q24 / half_pi;
    if (q > 4) q = 4;
    z = angle_q24 - q * half_pi;
    x = longint'(pcr_pkg::GAIN);
    y = 0;
    for (int i = 0; i < pcr_pkg::CORDIC_STAGES; i++) begin
      at = arctan_q24(i);
      if (z >= 0) begin
        t = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= at;
      end else begin
        t = x + floor_shift(y, i); y = y - floor_shift(x, i); z += at;
      end
      x = t;
    end
    case (q & 3)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    angle_q24 = (angle_q24 + step_q24) & ((longint'(1) << 27) - 1);
    px.last = angle_q24 >= two_pi_shifted(36);
    if (px.last) drawing = 1'b0;
    px.px = round_sat(ctr_x, c);
    px.py = round_sat(ctr_y, s);
    px.color = ink;
    return 1'b1;
  endfunction

  task automatic send_item(input logic cmd, input logic [15:0] cx, cy, ex, ey,
                           input logic [23:0] color, input bit fixed, input pixel_t want);
    pixel_t px;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {color, ey, ex, cy, cx};
    do @(posedge clk); while (!in_tready);
    if (rasterize(cmd, cx, cy, ex, ey, color, px)) begin
      if (fixed) px = want;
      pending_pixels.push_back(px);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    pixel_t w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("polar_circle_rasterizer test failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected transfer %h last %b err %b", $time,
                 out_tdata, out_tlast, out_tuser);
        fail_count++;
      end else begin
        w = pending_pixels.pop_front();
        if (out_tdata[15:0] !== w.px || out_tdata[31:16] !== w.py ||
            out_tdata[55:32] !== w.color || out_tlast !== w.last ||
            out_tuser !== w.error) begin
          $display("%0t: expected x %0d y %0d c %h last %b err %b, got x %0d y %0d c %h last %b err %b",
                   $time, $signed(w.px), $signed(w.py), w.color, w.last, w.error,
                   $signed(out_tdata[15:0]), $signed(out_tdata[31:16]), out_tdata[55:32],
                   out_tlast, out_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_item();
    logic [15:0] cx, cy, ex, ey;
    int r;
    pixel_t none;
    none = '{default: '0};
    cx = 16'($urandom); cy = 16'($urandom);
    r = $urandom_range(99);
    if (r < 10) begin
      // tiny radius, at most one pixel of offset
      ex = 16'(cx + $urandom_range(2) - 1); ey = 16'(cy + $urandom_range(2) - 1);
    end else if (r < 15) begin
      ex = cx; ey = cy;
    end else if (r < 25) begin
      ex = 16'($urandom); ey = 16'($urandom);
    end else begin
      cx = 16'($urandom_range(4000) - 2000); cy = 16'($urandom_range(4000) - 2000);
      ex = 16'(cx + $urandom_range(600) - 300); ey = 16'(cy + $urandom_range(600) - 300);
    end
    send_item(pcr_pkg::CMD_LOAD, cx, cy, ex, ey, 24'($urandom), 1'b0, none);
  endtask

  row_t dir_rows[$];
  initial begin
    pixel_t none, err;
    int sent, steps;
    none = '{default: '0};
    err = '{px: '0, py: '0, color: '0, last: 1'b0, error: 1'b1};
    drawing = 1'b0; ctr_x = 0; ctr_y = 0; radius_q8 = 0; step_q24 = 0; angle_q24 = 0;
    ink = '0;
    dir_rows = '{
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'h000000, 1'b0, none}, // idle step
      '{pcr_pkg::CMD_LOAD, 16'd5, 16'd5, 16'd5, 16'd5, 24'hFFFFFF, 1'b1, err},   // zero radius
      '{pcr_pkg::CMD_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'h123456, 1'b1, err},
      '{pcr_pkg::CMD_LOAD, 16'd0, 16'd0, 16'd1, 16'd0, 24'hFFFFFF, 1'b0, none},
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_STEP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, none},
      '{pcr_pkg::CMD_LOAD, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 24'hA5A5A5, 1'b0,
        none}, // huge
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_LOAD, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'h5A5A5A, 1'b0, none},
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_LOAD, 16'h7FF0, 16'h8010, 16'h7FF0, 16'h7FD0, 24'h000001, 1'b0,
        none}, // saturation
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none},
      '{pcr_pkg::CMD_LOAD, 16'd0, 16'd0, 16'd0, 16'd0, 24'h800000, 1'b1, err},
      '{pcr_pkg::CMD_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 24'd0, 1'b0, none}  // dropped after error
    };
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].color, dir_rows[i].fixed, dir_rows[i].want);
    // radius 1 circle drawn to completion: step gives 7 pixels, tests last
    send_item(pcr_pkg::CMD_LOAD, 16'd3, 16'hFFFD, 16'd3, 16'hFFFC, 24'h00FF00, 1'b0, none);
    while (drawing) send_item(pcr_pkg::CMD_STEP, '0, '0, '0, '0, '0, 1'b0, none);
    send_item(pcr_pkg::CMD_STEP, '0, '0, '0, '0, '0, 1'b0, none);

    // receiver held off while the sender keeps going
    hold_off = 1'b1;
    fork
      begin
        // large circle so that every step yields a pixel
        send_item(pcr_pkg::CMD_LOAD, 16'd0, 16'd0, 16'd100, 16'd0, 24'h0000FF, 1'b0, none);
        repeat (12) send_item(pcr_pkg::CMD_STEP, 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 24'($urandom), 1'b0, none);
      end
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      while (sent < N_RANDOM * (phase + 1) / 4) begin
        if ($urandom_range(99) < 8) begin
          random_item(); sent++;
        end else begin
          steps = $urandom_range(40, 1);
          repeat (steps) begin
            send_item(pcr_pkg::CMD_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 24'($urandom), 1'b0, none);
            sent++;
          end
          if ($urandom_range(99) < 5) wait_drained();
        end
      end
    end
    wait_drained();
    if (fail_count == 0) $display("polar_circle_rasterizer test passed");
    else $display("polar_circle_rasterizer test failed");
    $finish;
  end
endmodule
